FILE: sv/fmam_pkg.sv
`timescale 1ns / 1ps
// fmam_pkg: shared types, constants and the quarter-wave sine table for the
// FM/AM sine oscillator. No dependencies.
package fmam_pkg;

	localparam int PHASE_BITS  = 24;
	localparam int SAMPLE_BITS = 16;
	localparam int ACC_BITS    = 24;
	localparam int FREQ_BITS   = 23;
	localparam int GAIN_BITS   = 16;
	localparam int IDX_BITS    = 10;   // sine index of 10 bits, 1024 points per turn
	localparam int QTR_DEPTH   = 256;  // entries per quadrant
	localparam int MUL_A_BITS  = 24;   // serial multiplier, parallel operand
	localparam int MUL_B_BITS  = 18;   // serial multiplier, serial operand
	localparam int MUL_P_BITS  = MUL_A_BITS + MUL_B_BITS;
	localparam int CFG_IDX_BITS = 4;
	localparam int CFG_DATA_BITS = 32;

	// register map
	localparam logic [CFG_IDX_BITS-1:0] REG_FREQ     = 4'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_VOLUME   = 4'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_MODE     = 4'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_FM_RATE  = 4'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_FM_DEPTH = 4'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_AM_RATE  = 4'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_AM_DEPTH = 4'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_SLEW     = 4'd7;

	// mode bits
	localparam int MODE_FM  = 0;
	localparam int MODE_AM  = 1;
	localparam int MODE_OUT = 2;

	localparam longint unsigned Q30_ONE     = 64'd1 << 30;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned SINE_AMP    = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

	typedef logic [SAMPLE_BITS-2:0] qtab_t [0:QTR_DEPTH];

	// sin in Q30 on the first quadrant, odd Taylor series to x^11
	function automatic longint unsigned sin_q30(input longint unsigned x);
		longint unsigned x2;
		longint unsigned t;
		longint unsigned p;
		x2 = (x * x) >> 30;
		t = Q30_ONE;
		for (int k = 0; k < 5; k++) begin
			p = (x2 * t) >> 30;
			case (k)
				0: t = Q30_ONE - p / 110;
				1: t = Q30_ONE - p / 72;
				2: t = Q30_ONE - p / 42;
				3: t = Q30_ONE - p / 20;
				default: t = Q30_ONE - p / 6;
			endcase
		end
		return (x * t) >> 30;
	endfunction

	// quarter-wave table, entry r is the magnitude at r/256 of a quarter turn
	function automatic qtab_t build_qtab();
		qtab_t tab;
		longint unsigned x;
		longint unsigned v;
		for (int i = 0; i <= QTR_DEPTH; i++) begin
			x = (longint'(i) * HALF_PI_Q30) >> 8;
			v = (sin_q30(x) * SINE_AMP + (64'd1 << 29)) >> 30;
			tab[i] = v[SAMPLE_BITS-2:0];
		end
		return tab;
	endfunction

	localparam qtab_t QTAB = build_qtab();

	// move cur toward tgt by at most step
	function automatic logic [PHASE_BITS-1:0] slew(input logic [PHASE_BITS-1:0] cur,
			input logic [PHASE_BITS-1:0] tgt, input logic [15:0] step);
		logic [PHASE_BITS-1:0] d;
		logic [PHASE_BITS-1:0] st;
		logic [PHASE_BITS-1:0] res;
		st = {{(PHASE_BITS-16){1'b0}}, step};
		if (cur < tgt) begin
			d = tgt - cur;
			res = (d <= st) ? tgt : cur + st;
		end else begin
			d = cur - tgt;
			res = (d <= st) ? tgt : cur - st;
		end
		return res;
	endfunction

endpackage

FILE: sv/fmam_sine.sv
`timescale 1ns / 1ps
// fmam_sine: phase to sine sample lookup with registered output, built on
// the quarter-wave table. Depends on fmam_pkg.
module fmam_sine (
	input  logic                                  clk,
	input  logic [fmam_pkg::PHASE_BITS-1:0]       phase,
	output logic signed [fmam_pkg::SAMPLE_BITS-1:0] sine_q
);
	import fmam_pkg::*;

	logic [IDX_BITS-1:0]    idx;
	logic [1:0]             quad;
	logic [IDX_BITS-3:0]    pos;
	logic [IDX_BITS-2:0]    addr;
	logic [SAMPLE_BITS-1:0] mag;

	// fold the index into the first quadrant
	always_comb begin
		idx  = phase[PHASE_BITS-1 -: IDX_BITS];
		quad = idx[IDX_BITS-1 -: 2];
		pos  = idx[IDX_BITS-3:0];
		addr = quad[0] ? (9'(QTR_DEPTH) - {1'b0, pos}) : {1'b0, pos};
		mag  = {1'b0, QTAB[addr]};
	end

	always_ff @(posedge clk) begin
		sine_q <= quad[1] ? -signed'(mag) : signed'(mag);
	end

endmodule

FILE: sv/fmam_mul.sv
`timescale 1ns / 1ps
// fmam_mul: signed bit-serial shift-add multiplier, one bit of the serial
// operand per cycle. Depends on fmam_pkg.
module fmam_mul (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [fmam_pkg::MUL_A_BITS-1:0] op_a,
	input  logic signed [fmam_pkg::MUL_B_BITS-1:0] op_b,
	output logic                                   done_q,
	output logic signed [fmam_pkg::MUL_P_BITS-1:0] prod
);
	import fmam_pkg::*;

	localparam int CNT_BITS = $clog2(MUL_B_BITS);

	logic                         busy_q;
	logic [CNT_BITS-1:0]          cnt_q;
	logic signed [MUL_A_BITS-1:0] a_q;
	logic signed [MUL_A_BITS:0]   hi_q;
	logic [MUL_B_BITS-1:0]        lo_q;
	logic signed [MUL_A_BITS:0]   addend;
	logic signed [MUL_A_BITS+1:0] sum;
	logic                         last;

	// partial product; the sign bit of the serial operand has negative weight
	always_comb begin
		last = (cnt_q == CNT_BITS'(MUL_B_BITS - 1));
		if (!lo_q[0])
			addend = '0;
		else if (last)
			addend = -(MUL_A_BITS+1)'(a_q);
		else
			addend = (MUL_A_BITS+1)'(a_q);
		sum = (MUL_A_BITS+2)'(hi_q) + (MUL_A_BITS+2)'(addend);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift register pair: product bits enter lo_q as the operand leaves
	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= op_a;
			hi_q <= '0;
			lo_q <= op_b;
		end else if (busy_q) begin
			hi_q <= sum[MUL_A_BITS+1:1];
			lo_q <= {sum[0], lo_q[MUL_B_BITS-1:1]};
		end
	end

	assign prod = {hi_q[MUL_A_BITS-1:0], lo_q};

endmodule

FILE: sv/fm_am_sine_oscillator.sv
`timescale 1ns / 1ps
// FM/AM sine oscillator: phase accumulators, slew of the targets, sine
// lookup and saturating mix. Depends on fmam_pkg, fmam_sine, fmam_mul.
//
// One item is worked on at a time; in_stall is high from acceptance until
// the result beat is taken. An item with output disabled goes from the
// start state straight to the result beat, and one with new_frame low
// goes through the mix first. A new sample goes through a sequencer that
// shares one bit-serial multiplier, one bit per cycle, started once per
// product: slew, phase step, FM product, AM and gain products when
// enabled, carrier product, mix and result beat. A stalled result beat
// holds the block in its output state. Configuration writes are always
// accepted and are to be made while the block is idle.
module fm_am_sine_oscillator (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [fmam_pkg::CFG_IDX_BITS-1:0]         cfg_index,
	input  logic [fmam_pkg::CFG_DATA_BITS-1:0]        cfg_data,
	input  logic                                      in_valid,
	output logic                                      in_stall,
	input  logic signed [fmam_pkg::ACC_BITS-1:0]      accum_in,
	input  logic                                      new_frame,
	input  logic                                      restart,
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output logic signed [fmam_pkg::ACC_BITS-1:0]      accum_out,
	output logic signed [fmam_pkg::SAMPLE_BITS-1:0]   sample_out
);
	import fmam_pkg::*;

	typedef enum logic [17:0] {
		S_IDLE    = 18'h00001,
		S_START   = 18'h00002,
		S_SLEW    = 18'h00004,
		S_PHASE   = 18'h00008,
		S_FM_LU   = 18'h00010,
		S_FM_GO   = 18'h00020,
		S_FM_MUL  = 18'h00040,
		S_AM_LU   = 18'h00080,
		S_AM_GO   = 18'h00100,
		S_AM_MUL  = 18'h00200,
		S_GN_GO   = 18'h00400,
		S_GN_MUL  = 18'h00800,
		S_CAR     = 18'h01000,
		S_CAR_LU  = 18'h02000,
		S_CAR_GO  = 18'h04000,
		S_CAR_MUL = 18'h08000,
		S_ACC     = 18'h10000,
		S_OUT     = 18'h20000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [FREQ_BITS-1:0] tgt_freq_q, fm_rate_q, fm_depth_q, am_rate_q;
	logic [GAIN_BITS-1:0] tgt_vol_q, am_depth_q;
	logic [2:0]           mode_q;
	logic [31:0]          slew_q;

	// oscillator state
	logic [PHASE_BITS-1:0]  car_ph_q, fm_ph_q, am_ph_q;
	logic [FREQ_BITS-1:0]   freq_now_q, fm_rate_now_q, fm_depth_now_q, am_rate_now_q;
	logic [GAIN_BITS-1:0]   vol_now_q, am_depth_now_q;
	logic signed [SAMPLE_BITS-1:0] held_q;

	// per-item working registers
	logic signed [ACC_BITS-1:0]   acc_q;
	logic                         frame_q;
	logic [PHASE_BITS-1:0]        inc_q;
	logic signed [MUL_B_BITS-1:0] fac_q;
	logic signed [MUL_A_BITS-1:0] gain_q;
	logic signed [ACC_BITS-1:0]   accum_out_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;

	logic [PHASE_BITS-1:0]         sine_ph;
	logic signed [SAMPLE_BITS-1:0] sine_q;
	logic                          mul_start, mul_done;
	logic signed [MUL_A_BITS-1:0]  mul_a;
	logic signed [MUL_B_BITS-1:0]  mul_b;
	logic signed [MUL_P_BITS-1:0]  prod;
	logic signed [MUL_P_BITS-16:0] prod_sh;
	logic signed [SAMPLE_BITS-1:0] smp_sat;
	logic signed [ACC_BITS:0]      mix;
	logic signed [ACC_BITS-1:0]    mix_sat;
	logic                          in_acc;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = (state_q == S_OUT);
	assign accum_out = accum_out_q;
	assign sample_out = sample_out_q;

	// sine lookup address follows the sequencer
	always_comb begin
		case (state_q)
			S_FM_LU: sine_ph = fm_ph_q;
			S_AM_LU: sine_ph = am_ph_q;
			default: sine_ph = car_ph_q;
		endcase
	end

	fmam_sine u_sine (
		.clk    (clk),
		.phase  (sine_ph),
		.sine_q (sine_q)
	);

	// multiplier operand select
	always_comb begin
		mul_start = 1'b0;
		mul_a = gain_q;
		mul_b = MUL_B_BITS'(sine_q);
		case (state_q)
			S_FM_GO: begin
				mul_start = 1'b1;
				mul_a = MUL_A_BITS'({1'b0, fm_depth_now_q});
			end
			S_AM_GO: begin
				mul_start = 1'b1;
				mul_a = MUL_A_BITS'({1'b0, am_depth_now_q});
			end
			S_GN_GO: begin
				mul_start = 1'b1;
				mul_a = MUL_A_BITS'({1'b0, vol_now_q});
				mul_b = fac_q;
			end
			S_CAR_GO: mul_start = 1'b1;
			default: mul_start = 1'b0;
		endcase
	end

	fmam_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.done_q (mul_done),
		.prod   (prod)
	);

	// floor shift by 15, sample saturation and mix saturation
	always_comb begin
		prod_sh = prod[MUL_P_BITS-1:15];
		if (prod_sh > (MUL_P_BITS-15)'(32767))
			smp_sat = 16'sd32767;
		else if (prod_sh < -(MUL_P_BITS-15)'(32768))
			smp_sat = -16'sd32768;
		else
			smp_sat = prod_sh[SAMPLE_BITS-1:0];
		mix = (ACC_BITS+1)'(acc_q) + (ACC_BITS+1)'(held_q);
		if (mix[ACC_BITS] != mix[ACC_BITS-1])
			mix_sat = mix[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}}
				: {1'b0, {(ACC_BITS-1){1'b1}}};
		else
			mix_sat = mix[ACC_BITS-1:0];
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_freq_q <= '0;
			tgt_vol_q  <= '0;
			mode_q     <= '0;
			fm_rate_q  <= '0;
			fm_depth_q <= '0;
			am_rate_q  <= '0;
			am_depth_q <= '0;
			slew_q     <= '1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FREQ:     tgt_freq_q <= cfg_data[FREQ_BITS-1:0];
				REG_VOLUME:   tgt_vol_q  <= cfg_data[GAIN_BITS-1:0];
				REG_MODE:     mode_q     <= cfg_data[2:0];
				REG_FM_RATE:  fm_rate_q  <= cfg_data[FREQ_BITS-1:0];
				REG_FM_DEPTH: fm_depth_q <= cfg_data[FREQ_BITS-1:0];
				REG_AM_RATE:  am_rate_q  <= cfg_data[FREQ_BITS-1:0];
				REG_AM_DEPTH: am_depth_q <= cfg_data[GAIN_BITS-1:0];
				REG_SLEW:     slew_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and oscillator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			car_ph_q       <= '0;
			fm_ph_q        <= '0;
			am_ph_q        <= '0;
			freq_now_q     <= '0;
			vol_now_q      <= '0;
			fm_rate_now_q  <= '0;
			fm_depth_now_q <= '0;
			am_rate_now_q  <= '0;
			am_depth_now_q <= '0;
			held_q         <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_START;
						if (restart) begin
							freq_now_q     <= tgt_freq_q;
							vol_now_q      <= tgt_vol_q;
							fm_rate_now_q  <= fm_rate_q;
							fm_depth_now_q <= fm_depth_q;
							am_rate_now_q  <= am_rate_q;
							am_depth_now_q <= am_depth_q;
							car_ph_q       <= '0;
							fm_ph_q        <= '0;
							am_ph_q        <= '0;
						end
					end
				end
				S_START: begin
					if (!mode_q[MODE_OUT])
						state_q <= S_OUT;
					else if (frame_q)
						state_q <= S_SLEW;
					else
						state_q <= S_ACC;
				end
				S_SLEW: begin
					freq_now_q <= FREQ_BITS'(slew(PHASE_BITS'(freq_now_q),
						PHASE_BITS'(tgt_freq_q), slew_q[15:0]));
					vol_now_q <= GAIN_BITS'(slew(PHASE_BITS'(vol_now_q),
						PHASE_BITS'(tgt_vol_q), slew_q[31:16]));
					if (mode_q[MODE_FM]) begin
						fm_rate_now_q <= FREQ_BITS'(slew(PHASE_BITS'(fm_rate_now_q),
							PHASE_BITS'(fm_rate_q), slew_q[15:0]));
						fm_depth_now_q <= FREQ_BITS'(slew(PHASE_BITS'(fm_depth_now_q),
							PHASE_BITS'(fm_depth_q), slew_q[15:0]));
					end
					if (mode_q[MODE_AM]) begin
						am_rate_now_q <= FREQ_BITS'(slew(PHASE_BITS'(am_rate_now_q),
							PHASE_BITS'(am_rate_q), slew_q[15:0]));
						am_depth_now_q <= GAIN_BITS'(slew(PHASE_BITS'(am_depth_now_q),
							PHASE_BITS'(am_depth_q), slew_q[31:16]));
					end
					state_q <= S_PHASE;
				end
				S_PHASE: begin
					if (mode_q[MODE_FM])
						fm_ph_q <= fm_ph_q + PHASE_BITS'(fm_rate_now_q);
					if (mode_q[MODE_AM])
						am_ph_q <= am_ph_q + PHASE_BITS'(am_rate_now_q);
					if (mode_q[MODE_FM])
						state_q <= S_FM_LU;
					else if (mode_q[MODE_AM])
						state_q <= S_AM_LU;
					else
						state_q <= S_CAR;
				end
				S_FM_LU:  state_q <= S_FM_GO;
				S_FM_GO:  state_q <= S_FM_MUL;
				S_FM_MUL: begin
					if (mul_done)
						state_q <= mode_q[MODE_AM] ? S_AM_LU : S_CAR;
				end
				S_AM_LU:  state_q <= S_AM_GO;
				S_AM_GO:  state_q <= S_AM_MUL;
				S_AM_MUL: begin
					if (mul_done)
						state_q <= S_GN_GO;
				end
				S_GN_GO:  state_q <= S_GN_MUL;
				S_GN_MUL: begin
					if (mul_done)
						state_q <= S_CAR;
				end
				S_CAR: begin
					car_ph_q <= car_ph_q + inc_q;
					state_q  <= S_CAR_LU;
				end
				S_CAR_LU: state_q <= S_CAR_GO;
				S_CAR_GO: state_q <= S_CAR_MUL;
				S_CAR_MUL: begin
					if (mul_done) begin
						held_q  <= smp_sat;
						state_q <= S_ACC;
					end
				end
				S_ACC: state_q <= S_OUT;
				S_OUT: begin
					if (!out_stall)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// per-item datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			acc_q   <= accum_in;
			frame_q <= new_frame;
		end
		case (state_q)
			S_START: begin
				if (!mode_q[MODE_OUT]) begin
					accum_out_q  <= acc_q;
					sample_out_q <= '0;
				end
			end
			S_PHASE: begin
				inc_q  <= PHASE_BITS'(freq_now_q);
				gain_q <= MUL_A_BITS'({1'b0, vol_now_q});
			end
			S_FM_MUL: begin
				if (mul_done)
					inc_q <= PHASE_BITS'(freq_now_q) + prod_sh[PHASE_BITS-1:0];
			end
			S_AM_MUL: begin
				if (mul_done)
					fac_q <= MUL_B_BITS'(32768) + prod_sh[MUL_B_BITS-1:0];
			end
			S_GN_MUL: begin
				if (mul_done)
					gain_q <= prod_sh[MUL_A_BITS-1:0];
			end
			S_ACC: begin
				accum_out_q  <= mix_sat;
				sample_out_q <= held_q;
			end
			default: ;
		endcase
	end

endmodule
